/* rtl/snq_pkg.sv */
// ----------------------------------------------------------------------------
// snq_pkg
// Shared widths, stage payload types and the scale table of the quantizer.
// ----------------------------------------------------------------------------
package snq_pkg;

    localparam int NOTE_W    = 7;
    localparam int SEL_W     = 4;
    localparam int STEPS     = 12;
    localparam int POS_W     = 4;
    localparam int SUM_W     = 9;
    localparam int PROD_W    = 16;
    localparam int QUOT_W    = 5;
    localparam int DIST_W    = 4;
    localparam int CFG_IDX_W = 1;

    // Bias of eleven octaves keeps note - root + BIAS positive.
    localparam logic [SUM_W-1:0]  BIAS        = SUM_W'(132);
    // Reciprocal of twelve scaled by 2^11; exact for sums below 260.
    localparam logic [7:0]        RECIP_12    = 8'd171;
    localparam int                RECIP_SHIFT = 11;
    localparam logic [SUM_W-1:0]  STEPS_SUM   = SUM_W'(STEPS);
    localparam logic [POS_W:0]    STEPS_UP    = (POS_W+1)'(STEPS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE_SELECT = 1'b0,
        REG_KEY_ROOT     = 1'b1
    } cfg_reg_t;

    typedef logic [STEPS-1:0] tone_mask_t;

    typedef struct packed {
        logic [NOTE_W-1:0] note;
        tone_mask_t        mask;
        logic [SUM_W-1:0]  sum;
    } snq_s1_t;

    typedef struct packed {
        logic [NOTE_W-1:0] note;
        tone_mask_t        mask;
        logic [POS_W-1:0]  pos;
    } snq_s2_t;

    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic [DIST_W-1:0] dist_dn;
        logic [DIST_W-1:0] dist_up;
    } snq_s3_t;

    // Bit t is set when the scale holds the tone t semitones above the root.
    function automatic tone_mask_t scale_mask(input logic [SEL_W-1:0] sel);
        tone_mask_t m;
        case (sel)
            4'd1:    m = 12'hAB5;
            4'd2:    m = 12'h5AD;
            4'd3:    m = 12'h6AD;
            4'd4:    m = 12'h5AB;
            4'd5:    m = 12'hAD5;
            4'd6:    m = 12'h6B5;
            4'd7:    m = 12'h4A9;
            4'd8:    m = 12'h295;
            4'd9:    m = 12'h9AD;
            4'd10:   m = 12'h56B;
            4'd11:   m = 12'h555;
            default: m = 12'hFFF;
        endcase
        return m;
    endfunction

endpackage

/* rtl/scale_note_quantizer.sv */
// ----------------------------------------------------------------------------
// scale_note_quantizer
// Snaps a MIDI note to the nearest tone of the selected scale and key.
// ----------------------------------------------------------------------------
//  Channel   Signals                                   Direction
//  input     in_valid, in_stall, note_in               into the block
//  output    out_valid, out_stall, note_out            out of the block
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data into the block
//
// One note is taken every cycle while in_stall is low; a result passes
// through four register stages with a valid bit each.
// Reset clears the valid bits and sets the scale to chromatic, root 0.
// A stalled output holds its note; a bubble in front of it still advances,
// and in_stall rises only when every stage holds a note.
module scale_note_quantizer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [snq_pkg::NOTE_W-1:0]     note_in,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [snq_pkg::NOTE_W-1:0]     note_out,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [snq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [snq_pkg::NOTE_W-1:0]     cfg_data
);
    import snq_pkg::*;

    logic [SEL_W-1:0]   scale_sel_reg;
    logic [NOTE_W-1:0]  key_root_reg;
    logic               s1_valid;
    logic               s2_valid;
    logic               s3_valid;
    snq_s2_t            s2_data;
    snq_s3_t            s3_data;
    logic               out_en;
    logic               s3_en;
    logic               s2_en;
    logic               s1_en;

    assign out_en    = !out_valid || !out_stall;
    assign s3_en     = !s3_valid || out_en;
    assign s2_en     = !s2_valid || s3_en;
    assign s1_en     = !s1_valid || s2_en;
    assign in_stall  = !s1_en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_sel_reg <= '0;
            key_root_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SCALE_SELECT: scale_sel_reg <= cfg_data[SEL_W-1:0];
                REG_KEY_ROOT:     key_root_reg  <= cfg_data;
                default:          key_root_reg  <= key_root_reg;
            endcase
        end
    end

    snq_offset u_offset (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_load   (in_valid),
        .note_in   (note_in),
        .scale_sel (scale_sel_reg),
        .root      (key_root_reg),
        .s2_en     (s2_en),
        .s1_valid  (s1_valid),
        .s2_valid  (s2_valid),
        .s2_data   (s2_data)
    );

    snq_search u_search (
        .clk      (clk),
        .rst_n    (rst_n),
        .s3_en    (s3_en),
        .s2_valid (s2_valid),
        .s2_data  (s2_data),
        .s3_valid (s3_valid),
        .s3_data  (s3_data)
    );

    snq_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .out_en    (out_en),
        .s3_valid  (s3_valid),
        .s3_data   (s3_data),
        .out_valid (out_valid),
        .note_out  (note_out)
    );

endmodule

/* rtl/snq_offset.sv */
// ----------------------------------------------------------------------------
// snq_offset
// Two stages: biased note-to-root distance, then its position in the octave.
// ----------------------------------------------------------------------------
module snq_offset (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_load,
    input  logic [snq_pkg::NOTE_W-1:0]  note_in,
    input  logic [snq_pkg::SEL_W-1:0]   scale_sel,
    input  logic [snq_pkg::NOTE_W-1:0]  root,
    input  logic                        s2_en,
    output logic                        s1_valid,
    output logic                        s2_valid,
    output snq_pkg::snq_s2_t            s2_data
);
    import snq_pkg::*;

    logic                s1_valid_reg;
    logic                s2_valid_reg;
    snq_s1_t             s1_reg;
    snq_s1_t             s1_next;
    snq_s2_t             s2_reg;
    snq_s2_t             s2_next;
    logic [PROD_W-1:0]   prod;
    logic [QUOT_W-1:0]   quot;
    logic [SUM_W-1:0]    rem;

    always_comb
    begin
        s1_next.note = note_in;
        s1_next.mask = scale_mask(scale_sel);
        s1_next.sum  = {2'b00, note_in} + BIAS - {2'b00, root};
    end

    always_comb
    begin
        prod         = PROD_W'(s1_reg.sum) * PROD_W'(RECIP_12);
        quot         = prod[RECIP_SHIFT +: QUOT_W];
        rem          = s1_reg.sum - SUM_W'(quot) * STEPS_SUM;
        s2_next.note = s1_reg.note;
        s2_next.mask = s1_reg.mask;
        s2_next.pos  = rem[POS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (!s1_valid_reg || s2_en)
            begin
                s1_valid_reg <= in_load;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load && (!s1_valid_reg || s2_en))
        begin
            s1_reg <= s1_next;
        end
        if (s2_en && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s2_valid = s2_valid_reg;
    assign s2_data  = s2_reg;

endmodule

/* rtl/snq_search.sv */
// ----------------------------------------------------------------------------
// snq_search
// Finds the distances to the nearest scale tones at or below and at or above.
// ----------------------------------------------------------------------------
module snq_search (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s3_en,
    input  logic               s2_valid,
    input  snq_pkg::snq_s2_t   s2_data,
    output logic               s3_valid,
    output snq_pkg::snq_s3_t   s3_data
);
    import snq_pkg::*;

    logic              s3_valid_reg;
    snq_s3_t           s3_reg;
    snq_s3_t           s3_next;
    logic [POS_W-1:0]  tone_dn;
    logic [POS_W:0]    tone_up;

    always_comb
    begin
        tone_dn = '0;
        tone_up = STEPS_UP;
        for (int t = 0; t < STEPS; t++)
        begin
            if (s2_data.mask[t] && (POS_W'(t) <= s2_data.pos))
            begin
                tone_dn = POS_W'(t);
            end
        end
        for (int t = STEPS - 1; t >= 0; t--)
        begin
            if (s2_data.mask[t] && (POS_W'(t) >= s2_data.pos))
            begin
                tone_up = (POS_W+1)'(t);
            end
        end
        s3_next.note    = s2_data.note;
        s3_next.dist_dn = s2_data.pos - tone_dn;
        s3_next.dist_up = DIST_W'(tone_up - {1'b0, s2_data.pos});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_en)
        begin
            s3_valid_reg <= s2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_en && s2_valid)
        begin
            s3_reg <= s3_next;
        end
    end

    assign s3_valid = s3_valid_reg;
    assign s3_data  = s3_reg;

endmodule

/* rtl/snq_select.sv */
// ----------------------------------------------------------------------------
// snq_select
// Picks the closer in-range candidate, lower on a tie, into the output register.
// ----------------------------------------------------------------------------
module snq_select (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        out_en,
    input  logic                        s3_valid,
    input  snq_pkg::snq_s3_t            s3_data,
    output logic                        out_valid,
    output logic [snq_pkg::NOTE_W-1:0]  note_out
);
    import snq_pkg::*;

    logic                 out_valid_reg;
    logic [NOTE_W-1:0]    note_reg;
    logic [NOTE_W-1:0]    note_next;
    logic [NOTE_W:0]      cand_dn;
    logic [NOTE_W:0]      cand_up;
    logic                 dn_ok;
    logic                 up_ok;

    always_comb
    begin
        cand_dn = {1'b0, s3_data.note} - (NOTE_W+1)'(s3_data.dist_dn);
        cand_up = {1'b0, s3_data.note} + (NOTE_W+1)'(s3_data.dist_up);
        dn_ok   = !cand_dn[NOTE_W];
        up_ok   = !cand_up[NOTE_W];
        if (dn_ok && (!up_ok || (s3_data.dist_dn <= s3_data.dist_up)))
        begin
            note_next = cand_dn[NOTE_W-1:0];
        end
        else
        begin
            note_next = cand_up[NOTE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= s3_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en && s3_valid)
        begin
            note_reg <= note_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign note_out  = note_reg;

endmodule
